[design/ddgs_pkg.sv]
// ddgs_pkg: shared types, constants and helpers for the decimal digit glyph strip
// used by ddgs_div10 and decimal_digit_glyph_strip_unit; no dependencies
`timescale 1ns / 1ps

package ddgs_pkg;

    // field widths
    localparam int COORD_W  = 16;
    localparam int MAG_W    = 16;
    localparam int U_W      = 8;
    localparam int DIGIT_W  = 4;
    localparam int WIDTH_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // screen x step between neighboring glyphs
    localparam logic [COORD_W-1:0] DIGIT_STEP = COORD_W'(12);

    // most digits a 16-bit magnitude can have
    localparam int MAX_DIGITS = 5;
    localparam int DCNT_W     = $clog2(MAX_DIGITS);

    // glyph codes
    localparam logic [DIGIT_W-1:0] SIGN_CODE = DIGIT_W'(10);
    localparam logic [DIGIT_W-1:0] RADIX     = DIGIT_W'(10);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_BASE_U = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = CFG_IDX_W'(1);

    // reset values of the registers
    localparam logic [U_W-1:0]     ATLAS_BASE_U_RST = U_W'(0);
    localparam logic [WIDTH_W-1:0] GLYPH_WIDTH_RST  = WIDTH_W'(12);

    typedef struct packed {
        logic signed [COORD_W-1:0] number;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] glyph_x;
        logic signed [COORD_W-1:0] glyph_y;
        logic        [U_W-1:0]     glyph_u;
        logic        [DIGIT_W-1:0] digit;
        logic                      last_glyph;
    } out_item_t;

    // status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // atlas u: base plus code times width, modulo 256 (only low width bits matter)
    function automatic logic [U_W-1:0] glyph_u_of(
        input logic [U_W-1:0]     base,
        input logic [DIGIT_W-1:0] code,
        input logic [WIDTH_W-1:0] width
    );
        logic [U_W+DIGIT_W-1:0] prod;
        prod = code * width[U_W-1:0];
        return base + prod[U_W-1:0];
    endfunction

endpackage

[design/ddgs_div10.sv]
// ddgs_div10: bit-serial restoring divide by ten, one quotient bit per cycle
// depends on ddgs_pkg
`timescale 1ns / 1ps

module ddgs_div10 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ddgs_pkg::MAG_W-1:0]  dividend,
    output logic [ddgs_pkg::MAG_W-1:0]  quot,
    output logic [ddgs_pkg::DIGIT_W-1:0] rem,
    output ddgs_pkg::div_stat_t         stat
);

    localparam int CNT_W = $clog2(ddgs_pkg::MAG_W);

    logic [ddgs_pkg::MAG_W-1:0]   quot_reg;
    logic [ddgs_pkg::DIGIT_W-1:0] rem_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         run_reg;
    logic                         done_reg;

    logic [ddgs_pkg::DIGIT_W:0]   trial;
    logic                         qbit;
    logic [ddgs_pkg::DIGIT_W-1:0] rem_next;

    // partial remainder with the next dividend bit shifted in
    always_comb
    begin
        trial = {rem_reg, quot_reg[ddgs_pkg::MAG_W-1]};
        qbit  = trial >= {1'b0, ddgs_pkg::RADIX};
        if (qbit)
        begin
            rem_next = ddgs_pkg::DIGIT_W'(trial - {1'b0, ddgs_pkg::RADIX});
        end
        else
        begin
            rem_next = trial[ddgs_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quot_reg <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                quot_reg <= {quot_reg[ddgs_pkg::MAG_W-2:0], qbit};
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ddgs_pkg::MAG_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = quot_reg;
    assign rem       = rem_reg;
    assign stat.busy = run_reg;
    assign stat.done = done_reg;

endmodule

[design/decimal_digit_glyph_strip_unit.sv]
// decimal_digit_glyph_strip_unit: top level, number in, one glyph placement beat per digit out
// depends on ddgs_pkg and ddgs_div10
// each digit: bit-serial divide by ten in ddgs_div10, its done flag, then the output load
// a negative number gets one more glyph, a minus sign, after its last digit; a new
//   number is taken only in idle, once the last glyph of the one before is loaded;
//   a stalled output holds the unit in S_PUT or S_SIGN until the slot frees
// reset: async active low, returns to idle with atlas_base_u = 0, glyph_width = 12
`timescale 1ns / 1ps

module decimal_digit_glyph_strip_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ddgs_pkg::in_item_t               in_data,
    // glyph beats
    output logic                             out_valid,
    input  logic                             out_ready,
    output ddgs_pkg::out_item_t              out_data,
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ddgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ddgs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUT,
        S_SIGN
    } state_t;

    state_t state_reg;

    // configuration
    logic [ddgs_pkg::U_W-1:0]     atlas_base_u_reg;
    logic [ddgs_pkg::WIDTH_W-1:0] glyph_width_reg;

    // strip context
    logic [ddgs_pkg::COORD_W-1:0] x_reg;
    logic [ddgs_pkg::COORD_W-1:0] y_reg;
    logic                         sign_reg;
    logic [ddgs_pkg::DCNT_W-1:0]  count_reg;

    // output register
    logic                 out_valid_reg;
    ddgs_pkg::out_item_t  out_data_reg;

    // divider hookup
    logic                          div_start;
    logic [ddgs_pkg::MAG_W-1:0]    div_dividend;
    logic [ddgs_pkg::MAG_W-1:0]    div_quot;
    logic [ddgs_pkg::DIGIT_W-1:0]  div_rem;
    ddgs_pkg::div_stat_t           div_stat;

    logic                          in_fire;
    logic                          slot_free;
    logic                          glyph_load;
    logic                          quot_zero;
    logic                          more_digits;
    logic [ddgs_pkg::MAG_W-1:0]    magnitude;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // output slot can take a glyph when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // a digit or sign glyph goes into the output slot this cycle
    assign glyph_load = ((state_reg == S_PUT) || (state_reg == S_SIGN)) && slot_free;

    // two's complement magnitude, -32768 comes out as 0x8000 = 32768
    assign magnitude = in_data.number[ddgs_pkg::COORD_W-1]
                     ? ddgs_pkg::MAG_W'(~in_data.number + 1'b1)
                     : ddgs_pkg::MAG_W'(in_data.number);

    assign quot_zero   = (div_quot == '0);
    assign more_digits = !quot_zero
                      && (count_reg != ddgs_pkg::DCNT_W'(ddgs_pkg::MAX_DIGITS - 1));

    // start on a fresh number, or on the quotient when another digit follows
    assign div_start    = in_fire || ((state_reg == S_PUT) && slot_free && more_digits);
    assign div_dividend = (state_reg == S_IDLE) ? magnitude : div_quot;

    ddgs_div10 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .quot     (div_quot),
        .rem      (div_rem),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            atlas_base_u_reg <= ddgs_pkg::ATLAS_BASE_U_RST;
            glyph_width_reg  <= ddgs_pkg::GLYPH_WIDTH_RST;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            sign_reg         <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            // register writes, unknown indexes dropped
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ddgs_pkg::REG_ATLAS_BASE_U:
                        atlas_base_u_reg <= cfg_data[ddgs_pkg::U_W-1:0];
                    ddgs_pkg::REG_GLYPH_WIDTH:
                        glyph_width_reg <= cfg_data[ddgs_pkg::WIDTH_W-1:0];
                    default: ;
                endcase
            end

            // slot refilled with a new glyph, or emptied when taken downstream
            if (glyph_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        x_reg     <= in_data.start_x;
                        y_reg     <= in_data.start_y;
                        sign_reg  <= in_data.number[ddgs_pkg::COORD_W-1];
                        count_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_PUT;
                    end
                end

                S_PUT:
                begin
                    if (slot_free)
                    begin
                        out_data_reg.glyph_x    <= x_reg;
                        out_data_reg.glyph_y    <= y_reg;
                        out_data_reg.glyph_u    <= ddgs_pkg::glyph_u_of(
                            atlas_base_u_reg, div_rem, glyph_width_reg);
                        out_data_reg.digit      <= div_rem;
                        out_data_reg.last_glyph <= quot_zero && !sign_reg;
                        x_reg                   <= x_reg - ddgs_pkg::DIGIT_STEP;
                        count_reg               <= count_reg + 1'b1;
                        if (more_digits)
                        begin
                            state_reg <= S_DIV;
                        end
                        else if (sign_reg)
                        begin
                            state_reg <= S_SIGN;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_SIGN:
                begin
                    // minus glyph sits at the x reached after the last digit step
                    if (slot_free)
                    begin
                        out_data_reg.glyph_x    <= x_reg;
                        out_data_reg.glyph_y    <= y_reg;
                        out_data_reg.glyph_u    <= ddgs_pkg::glyph_u_of(
                            atlas_base_u_reg, ddgs_pkg::SIGN_CODE, glyph_width_reg);
                        out_data_reg.digit      <= ddgs_pkg::SIGN_CODE;
                        out_data_reg.last_glyph <= 1'b1;
                        sign_reg                <= 1'b0;
                        state_reg               <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // divider only runs while a number is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider running while idle");

    // a sign glyph always closes the strip
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.digit == ddgs_pkg::SIGN_CODE)) |-> out_data.last_glyph)
        else $error("sign glyph without last flag");

    // accepted number goes straight into the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> ((state_reg == S_DIV) && div_stat.busy))
        else $error("divider not started on accepted number");

endmodule
